>>> rtl/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg
// shared types, status codes and header tag table for the wav stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package wsm_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned PosWidth    = 6;

   localparam logic [PosWidth-1:0] HeaderLast  = 6'd43;
   localparam logic [PosWidth-1:0] ChanLoPos   = 6'd22;
   localparam logic [PosWidth-1:0] ChanHiPos   = 6'd23;
   localparam logic [PosWidth-1:0] SizeFirstPos = 6'd40;

   typedef logic [StatusWidth-1:0] status_type;

   localparam status_type ST_SAMPLE       = 3'd0;
   localparam status_type ST_BAD_RIFF     = 3'd1;
   localparam status_type ST_BAD_WAVE     = 3'd2;
   localparam status_type ST_BAD_FMT      = 3'd3;
   localparam status_type ST_BAD_DATA     = 3'd4;
   localparam status_type ST_BAD_CHANNELS = 3'd5;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_HEADER = 4'b0010,
      MODE_DATA   = 4'b0100,
      MODE_DONE   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic                   valid;
      logic signed [SampleWidth-1:0] sample;
      status_type             status;
      logic                   last;
   } result_type;

   typedef struct packed {
      status_type             code;
      logic [ByteWidth-1:0]   expect_byte;
   } tag_type;

   // tag bytes of the canonical header, code zero where no tag sits
   function automatic tag_type tag_lookup(logic [PosWidth-1:0] pos);
      tag_type t;
      t.code        = ST_SAMPLE;
      t.expect_byte = '0;
      case (pos)
         6'd0:  t = '{ST_BAD_RIFF, 8'h52};  // R
         6'd1:  t = '{ST_BAD_RIFF, 8'h49};  // I
         6'd2:  t = '{ST_BAD_RIFF, 8'h46};  // F
         6'd3:  t = '{ST_BAD_RIFF, 8'h46};  // F
         6'd8:  t = '{ST_BAD_WAVE, 8'h57};  // W
         6'd9:  t = '{ST_BAD_WAVE, 8'h41};  // A
         6'd10: t = '{ST_BAD_WAVE, 8'h56};  // V
         6'd11: t = '{ST_BAD_WAVE, 8'h45};  // E
         6'd12: t = '{ST_BAD_FMT,  8'h66};  // f
         6'd13: t = '{ST_BAD_FMT,  8'h6d};  // m
         6'd14: t = '{ST_BAD_FMT,  8'h74};  // t
         6'd15: t = '{ST_BAD_FMT,  8'h20};  // space
         6'd36: t = '{ST_BAD_DATA, 8'h64};  // d
         6'd37: t = '{ST_BAD_DATA, 8'h61};  // a
         6'd38: t = '{ST_BAD_DATA, 8'h74};  // t
         6'd39: t = '{ST_BAD_DATA, 8'h61};  // a
         default: t = '{ST_SAMPLE, 8'h00};
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

>>> rtl/wsm_parse.sv
// ----------------------------------------------------------------------------
// wsm_parse
// header parser and sample builder, one byte per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_parse (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_en,
   input  wire logic [wsm_pkg::ByteWidth-1:0] byte_in,
   input  wire logic                         start_of_file,
   output wsm_pkg::result_type               result
);

   import wsm_pkg::*;

   mode_type              mode_ff,    mode_in;
   logic [PosWidth-1:0]   pos_ff,     pos_in;
   logic [15:0]           chan_ff,    chan_in;
   logic [31:0]           remain_ff,  remain_in;
   logic [23:0]           held_ff,    held_in;
   logic [1:0]            phase_ff,   phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         chan_ff   <= '0;
         remain_ff <= '0;
         held_ff   <= '0;
         phase_ff  <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         chan_ff   <= chan_in;
         remain_ff <= remain_in;
         held_ff   <= held_in;
         phase_ff  <= phase_in;
      end
   end

   always_comb begin
      mode_type                   mode_cur;
      logic [PosWidth-1:0]        pos_cur;
      logic [15:0]                chan_cur;
      logic [31:0]                remain_cur;
      logic [23:0]                held_cur;
      logic [1:0]                 phase_cur;
      tag_type                    tag;
      logic [31:0]                remain_dec;
      logic [2:0]                 frame_size;
      logic signed [15:0]         left;
      logic signed [15:0]         right;
      logic signed [16:0]         total;
      logic signed [16:0]         halved;

      mode_cur   = mode_ff;
      pos_cur    = pos_ff;
      chan_cur   = chan_ff;
      remain_cur = remain_ff;
      held_cur   = held_ff;
      phase_cur  = phase_ff;
      if (start_of_file) begin
         mode_cur   = MODE_HEADER;
         pos_cur    = '0;
         chan_cur   = '0;
         remain_cur = '0;
         held_cur   = '0;
         phase_cur  = '0;
      end

      mode_in   = mode_cur;
      pos_in    = pos_cur;
      chan_in   = chan_cur;
      remain_in = remain_cur;
      held_in   = held_cur;
      phase_in  = phase_cur;

      result = '{valid: 1'b0, sample: '0, status: ST_SAMPLE, last: 1'b0};

      tag        = tag_lookup(pos_cur);
      remain_dec = remain_cur - 32'd1;
      frame_size = (chan_cur == 16'd2) ? 3'd4 : 3'd2;
      left       = signed'(held_cur[15:0]);
      right      = signed'({byte_in, held_cur[23:16]});
      total      = 17'(left) + 17'(right);
      halved     = (total + 17'(total[16])) >>> 1;

      case (mode_cur)
         MODE_HEADER: begin
            if (tag.code != ST_SAMPLE && byte_in != tag.expect_byte) begin
               mode_in       = MODE_DONE;
               result.valid  = 1'b1;
               result.status = tag.code;
            end else begin
               if (pos_cur == ChanLoPos) begin
                  chan_in = {chan_cur[15:8], byte_in};
               end else if (pos_cur == ChanHiPos) begin
                  chan_in = {byte_in, chan_cur[7:0]};
               end else if (pos_cur >= SizeFirstPos && pos_cur <= HeaderLast) begin
                  case (pos_cur[1:0])
                     2'd0:    remain_in = {remain_cur[31:8], byte_in};
                     2'd1:    remain_in = {remain_cur[31:16], byte_in, remain_cur[7:0]};
                     2'd2:    remain_in = {remain_cur[31:24], byte_in, remain_cur[15:0]};
                     default: remain_in = {byte_in, remain_cur[23:0]};
                  endcase
               end
               if (pos_cur >= HeaderLast) begin
                  phase_in = '0;
                  held_in  = '0;
                  if (chan_in != 16'd1 && chan_in != 16'd2) begin
                     mode_in       = MODE_DONE;
                     result.valid  = 1'b1;
                     result.status = ST_BAD_CHANNELS;
                  end else begin
                     mode_in = (remain_in == 32'd0) ? MODE_DONE : MODE_DATA;
                  end
               end else begin
                  pos_in = pos_cur + 6'd1;
               end
            end
         end
         MODE_DATA: begin
            remain_in = remain_dec;
            if ({1'b0, phase_cur} + 3'd1 >= frame_size) begin
               phase_in      = '0;
               held_in       = '0;
               result.valid  = 1'b1;
               result.status = ST_SAMPLE;
               result.last   = (remain_dec < 32'(frame_size));
               if (frame_size == 3'd2) begin
                  result.sample = signed'({byte_in, held_cur[7:0]});
               end else begin
                  result.sample = halved[15:0];
               end
            end else begin
               case (phase_cur)
                  2'd0:    held_in = {held_cur[23:8], byte_in};
                  2'd1:    held_in = {held_cur[23:16], byte_in, held_cur[7:0]};
                  default: held_in = {byte_in, held_cur[15:0]};
               endcase
               phase_in = phase_cur + 2'd1;
            end
            if (remain_dec == 32'd0) begin
               mode_in = MODE_DONE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/wav_stream_to_mono_samples.sv
// ----------------------------------------------------------------------------
// wav_stream_to_mono_samples
// canonical 44-byte wav header parser giving mono 16-bit samples
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while results are taken, with no gaps needed
// between bytes. Each byte passes an input register and then the parse logic,
// which updates the header and frame state and loads at most one result into
// the output register. A full output register that is not taken holds back the
// input register, and with it req_tready. There is no clearing pass after reset.
`default_nettype none

module wav_stream_to_mono_samples (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [wsm_pkg::ByteWidth-1:0]  req_tdata,   // byte_in
   input  wire logic                           req_tuser,   // start_of_file
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [wsm_pkg::SampleWidth-1:0]     rsp_tdata,   // sample_value
   output wsm_pkg::status_type                 rsp_tuser,   // status_code
   output logic                                rsp_tlast    // last_sample
);

   import wsm_pkg::*;

   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_sof_ff;
   result_type            out_ff;
   result_type            step_result;
   logic                  out_free;
   logic                  step_en;

   assign out_free   = !out_ff.valid || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_sof_ff  <= req_tuser;
      end
   end

   wsm_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .byte_in       (in_byte_ff),
      .start_of_file (in_sof_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (step_en && step_result.valid) begin
         out_ff.valid <= 1'b1;
      end else if (rsp_tready) begin
         out_ff.valid <= 1'b0;
      end
      if (step_en && step_result.valid) begin
         out_ff.sample <= step_result.sample;
         out_ff.status <= step_result.status;
         out_ff.last   <= step_result.last;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = out_ff.sample;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;

endmodule

`default_nettype wire

>>> rtl/wsm_checker.sv
// ----------------------------------------------------------------------------
// wsm_checker
// port-level checks on the result stream of the wav parser
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [wsm_pkg::SampleWidth-1:0] rsp_tdata,
   input  wire wsm_pkg::status_type            rsp_tuser,
   input  wire logic                           rsp_tlast
);

   import wsm_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // error words carry zero sample and no last flag
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_SAMPLE |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("error word with sample or last");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_BAD_CHANNELS)
      else $error("undefined status code");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // a fresh word needs an earlier accepted input byte or a stalled input
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && !$past(reset) |-> $past(req_tvalid && req_tready, 2)
         || $past(!req_tready, 1))
      else $error("result word without input");

endmodule

bind wav_stream_to_mono_samples wsm_checker u_checker (.*);

`default_nettype wire
